// ===== sv/assert_macros.svh =====
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle property.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Antecedent in one cycle, consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/stq_pkg.sv =====
`default_nettype none
package stq_pkg;

   localparam int MAX_FIRE = 16;
   localparam int FIRE_W   = $clog2(MAX_FIRE);

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] KIND_ACCEPTED = 2'd0;
   localparam logic [1:0] KIND_REJECTED = 2'd1;
   localparam logic [1:0] KIND_EXPIRED  = 2'd2;

   localparam logic [31:0] CLOCK_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        op;
      logic [7:0]  event_tag;
      logic [31:0] wait_seconds;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  fired_tag;
      logic [31:0] start_time;
      logic [31:0] span;
      logic [31:0] now_time;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [32:0] deadline;
      logic [31:0] start;
      logic [31:0] span;
      logic [7:0]  tag;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ===== sv/sorted_timeout_queue.sv =====
`default_nettype none
// channel | dir | handshake            | payload
// req     | in  | req_valid/req_ready  | req_data (op, event_tag, wait_seconds)
// rsp     | out | rsp_valid/rsp_ready  | rsp_data (kind, tag, times, span, last)
//
// Add: one response; insertion is done in place by the cell row.
// Tick: step the seconds counter, then pop expired events one at a time from
//   the head cell, at most MAX_FIRE per tick; with none due it returns to idle.
// Responses sit in one output register; a stalled rsp holds the drain.
// Synchronous reset: counter zero, all cells empty, no response pending.
`include "assert_macros.svh"
module sorted_timeout_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  stq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output stq_pkg::rsp_type rsp_data
);
   import stq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic [31:0]       clock_ff, clock_in;
   logic [FIRE_W-1:0] fire_ff, fire_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Chain: slot 0 and slot QUEUE_DEPTH+1 are the open ends, cell i sits
   // in slot i+1 with its neighbors at i and i+2.
   entry_type                entry_chain [QUEUE_DEPTH+2];
   logic [QUEUE_DEPTH+1:0]   valid_chain;
   logic [QUEUE_DEPTH:0]     gt_chain;
   logic [QUEUE_DEPTH-1:0]   held_vec;
   entry_type                new_entry;
   cell_ctrl_type            ctrl;

   logic req_xfer, out_free, full, due0, due1, emit, last_fire;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_xfer  = req_valid && req_ready;
   assign full      = valid_chain[QUEUE_DEPTH];

   assign new_entry.deadline = {1'b0, clock_ff} + {1'b0, req_data.wait_seconds};
   assign new_entry.start    = clock_ff;
   assign new_entry.span     = req_data.wait_seconds;
   assign new_entry.tag      = req_data.event_tag;

   assign entry_chain[0]             = new_entry;
   assign entry_chain[QUEUE_DEPTH+1] = new_entry;
   assign valid_chain[0]             = 1'b0;
   assign valid_chain[QUEUE_DEPTH+1] = 1'b0;
   assign gt_chain[0]                = 1'b0;
   assign held_vec                   = valid_chain[QUEUE_DEPTH:1];

   // Head due checks; the second one, with the fire count, says whether the pop is the last.
   assign due0 = valid_chain[1] && (entry_chain[1].deadline <= {1'b0, clock_ff});
   assign due1 = valid_chain[2] && (entry_chain[2].deadline <= {1'b0, clock_ff});
   assign emit = (state_ff == ST_DRAIN) && due0 && out_free;
   assign last_fire = !due1 || (fire_ff == FIRE_W'(MAX_FIRE - 1));

   assign ctrl.insert = req_xfer && (req_data.op == OP_ADD) && !full;
   assign ctrl.pop    = emit;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      stq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .left_entry  (entry_chain[i]),
         .left_valid  (valid_chain[i]),
         .left_gt     (gt_chain[i]),
         .right_entry (entry_chain[i+2]),
         .right_valid (valid_chain[i+2]),
         .entry       (entry_chain[i+1]),
         .valid       (valid_chain[i+1]),
         .gt          (gt_chain[i+1])
      );
   end

   always_comb begin
      state_in     = state_ff;
      clock_in     = clock_ff;
      fire_in      = fire_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               unique case (req_data.op)
                  OP_ADD: begin
                     rsp_in.kind       = full ? KIND_REJECTED : KIND_ACCEPTED;
                     rsp_in.fired_tag  = req_data.event_tag;
                     rsp_in.start_time = clock_ff;
                     rsp_in.span       = req_data.wait_seconds;
                     rsp_in.now_time   = clock_ff;
                     rsp_in.last       = 1'b1;
                     rsp_valid_in      = 1'b1;
                  end
                  OP_TICK: begin
                     if (clock_ff != CLOCK_MAX) begin
                        clock_in = clock_ff + 32'd1;
                     end
                     fire_in  = '0;
                     state_in = ST_DRAIN;
                  end
                  default: ;
               endcase
            end
         end
         ST_DRAIN: begin
            if (!due0) begin
               state_in = ST_IDLE;
            end else if (emit) begin
               rsp_in.kind       = KIND_EXPIRED;
               rsp_in.fired_tag  = entry_chain[1].tag;
               rsp_in.start_time = entry_chain[1].start;
               rsp_in.span       = entry_chain[1].span;
               rsp_in.now_time   = clock_ff;
               rsp_in.last       = last_fire;
               rsp_valid_in      = 1'b1;
               fire_in           = fire_ff + FIRE_W'(1);
               if (last_fire) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      fire_ff <= fire_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         clock_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clock_ff     <= clock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // held cells always form a prefix of the row
   `ASSERT_CLK(a_prefix, clock, reset, ((held_vec >> 1) & ~held_vec) == '0)
   // a free last cell always offers an insertion slot
   `ASSERT_CLK(a_slot, clock, reset, full || gt_chain[QUEUE_DEPTH])
   // an accepted add grows the queue by exactly one
   `ASSERT_NEXT(a_grow, clock, reset, req_xfer && (req_data.op == OP_ADD) && !full,
      $countones(held_vec) == $countones($past(held_vec)) + 1)
   // a tick steps the counter unless it has saturated
   `ASSERT_NEXT(a_step, clock, reset, req_xfer && (req_data.op == OP_TICK),
      (clock_ff == $past(clock_ff) + 32'd1) || ($past(clock_ff) == CLOCK_MAX))

endmodule
`default_nettype wire

// ===== sv/stq_cell.sv =====
`default_nettype none
module stq_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  stq_pkg::cell_ctrl_type ctrl,
   input  stq_pkg::entry_type     new_entry,
   input  stq_pkg::entry_type     left_entry,
   input  wire                    left_valid,
   input  wire                    left_gt,
   input  stq_pkg::entry_type     right_entry,
   input  wire                    right_valid,
   output stq_pkg::entry_type     entry,
   output logic                   valid,
   output logic                   gt
);
   import stq_pkg::*;

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;

   // empty or later deadline: new entry goes here or before
   assign gt = !valid_ff || (entry_ff.deadline > new_entry.deadline);

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      priority if (ctrl.pop) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end else if (ctrl.insert && left_gt) begin
         entry_in = left_entry;
         valid_in = left_valid;
      end else if (ctrl.insert && gt) begin
         entry_in = new_entry;
         valid_in = 1'b1;
      end else begin
         // hold
         entry_in = entry_ff;
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none
module testbench;
   import stq_pkg::*;

   localparam int DEPTH        = 16;
   localparam int SETTLE_CYCLES = 10;     // a tick with nothing due still passes through the drain check
   localparam int CYCLE_LIMIT  = 100000;
   localparam int MAX_BIG_WAITS = 5;      // huge waits never expire, so they eat cells for good
   localparam int MAX_REPORTS  = 40;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Timer model: deadline-ordered pending list plus the seconds count.
   entry_type   timer_list[$];
   logic [31:0] model_seconds = '0;
   rsp_type     awaited_rsps[$];

   // Pacing knobs shared between the sequence and the response sink.
   bit pace_sender     = 1'b0;
   bit pace_receiver   = 1'b0;
   int hold_off_cycles = 0;

   int mismatch_count  = 0;
   int cycle_count     = 0;
   int reqs_sent       = 0;
   int big_waits       = 0;
   int seen_accepted   = 0;
   int seen_rejected   = 0;
   int seen_expired    = 0;

   sorted_timeout_queue #(
      .QUEUE_DEPTH (DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still awaited", $time, awaited_rsps.size());
         $display("testbench failed");
         $finish;
      end
   end

   // Apply one accepted request to the model and queue what it must produce.
   // Add: always exactly one response, rejected when every cell is taken.
   // Tick: bump the count (it sticks at the top), then pop due entries from
   // the head, at most MAX_FIRE per tick; the final pop carries last.
   function automatic void predict_timer_results(input req_type item);
      rsp_type     r;
      entry_type   e;
      logic [32:0] due;
      int          pos;
      int          i;
      int          fired;
      bit          more;
      if (item.op == OP_ADD) begin
         r.kind       = (timer_list.size() >= DEPTH) ? KIND_REJECTED : KIND_ACCEPTED;
         r.fired_tag  = item.event_tag;
         r.start_time = model_seconds;
         r.span       = item.wait_seconds;
         r.now_time   = model_seconds;
         r.last       = 1'b1;
         if (r.kind == KIND_ACCEPTED) begin
            e.deadline = {1'b0, model_seconds} + {1'b0, item.wait_seconds};
            e.start    = model_seconds;
            e.span     = item.wait_seconds;
            e.tag      = item.event_tag;
            // equal deadlines keep arrival order: go after every deadline <= ours
            pos = timer_list.size();
            for (i = 0; i < timer_list.size(); i++) begin
               if (timer_list[i].deadline > e.deadline) begin
                  pos = i;
                  break;
               end
            end
            timer_list.insert(pos, e);
         end
         awaited_rsps.push_back(r);
      end else begin
         if (model_seconds != CLOCK_MAX) begin
            model_seconds++;
         end
         due   = {1'b0, model_seconds};
         fired = 0;
         while (fired < MAX_FIRE && timer_list.size() > 0 &&
                timer_list[0].deadline <= due) begin
            e = timer_list.pop_front();
            fired++;
            more = fired < MAX_FIRE && timer_list.size() > 0 &&
                   timer_list[0].deadline <= due;
            r.kind       = KIND_EXPIRED;
            r.fired_tag  = e.tag;
            r.start_time = e.start;
            r.span       = e.span;
            r.now_time   = model_seconds;
            r.last       = !more;
            awaited_rsps.push_back(r);
         end
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         end
      end
   endfunction

   // Compare one response transfer against the oldest awaited result.
   function automatic void check_timer_result(input rsp_type got);
      rsp_type want;
      if (awaited_rsps.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: unexpected response, expected none actual %h", $time, got);
         end
         return;
      end
      want = awaited_rsps.pop_front();
      check_field("kind",       32'(want.kind),      32'(got.kind));
      check_field("fired_tag",  32'(want.fired_tag), 32'(got.fired_tag));
      check_field("start_time", want.start_time,     got.start_time);
      check_field("span",       want.span,           got.span);
      check_field("now_time",   want.now_time,       got.now_time);
      check_field("last",       32'(want.last),      32'(got.last));
      case (got.kind)
         KIND_ACCEPTED: seen_accepted++;
         KIND_REJECTED: seen_rejected++;
         default:       seen_expired++;
      endcase
   endfunction

   // Response sink: random stall before each transfer, or a long hold-off
   // when the sequence asks for one. Ready stays high until a transfer lands.
   initial begin : rsp_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = pace_receiver ? $urandom_range(0, 4) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         check_timer_result(rsp_data);
      end
   end

   // One request transfer: optional gap, then hold valid and payload until taken.
   task automatic send_req(input req_type item);
      int gap;
      gap = pace_sender ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predict_timer_results(item);
      reqs_sent++;
   endtask

   task automatic send_add(input logic [7:0] tag, input logic [31:0] secs);
      req_type item;
      item.op           = OP_ADD;
      item.event_tag    = tag;
      item.wait_seconds = secs;
      send_req(item);
   endtask

   task automatic send_tick();
      req_type item;
      item.op           = OP_TICK;
      item.event_tag    = 8'($urandom());    // ignored on a tick
      item.wait_seconds = $urandom();
      send_req(item);
   endtask

   // Stop offering and let every awaited response arrive, then let the
   // block finish the drain check of any tick that produced nothing.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Fill every cell with deadlines 0 and 1 interleaved, overflow once,
   // then one tick releases the whole queue in deadline-then-arrival order.
   task automatic test_full_queue();
      int i;
      pace_sender   = 1'b0;
      pace_receiver = 1'b0;
      for (i = 0; i < DEPTH; i++) begin
         send_add(8'(i * 17), 32'(i % 2));
      end
      send_add(8'hFF, 32'hFFFF_FFFF);    // rejected: full
      send_tick();
      wait_drained();
   endtask

   // Field extremes, zero duration, a wait that can never come due, and
   // a tick with nothing due.
   task automatic test_extremes();
      pace_sender   = 1'b1;
      pace_receiver = 1'b1;
      send_add(8'h00, 32'h0000_0000);
      send_add(8'hFF, 32'hFFFF_FFFF);
      big_waits++;
      send_add(8'h5A, 32'h0000_0001);
      send_tick();
      send_tick();
      wait_drained();
   endtask

   // Long receiver hold-off while the sender keeps pushing: the response
   // register fills and request transfers must stall.
   task automatic test_backpressure();
      int i;
      pace_sender     = 1'b0;
      pace_receiver   = 1'b0;
      hold_off_cycles = 80;
      for (i = 0; i < 20; i++) begin
         if (i % 4 == 3) begin
            send_tick();
         end else begin
            send_add(8'($urandom()), $urandom_range(0, 3));
         end
      end
      wait_drained();
   endtask

   // Random adds and ticks; short waits keep the queue cycling, with a few
   // full-range waits that park for good.
   task automatic test_random_mix(input int count);
      int          n;
      logic [31:0] secs;
      for (n = 0; n < count; n++) begin
         if (n % 32 == 0) begin
            pace_sender   = $urandom_range(0, 3) != 0;
            pace_receiver = $urandom_range(0, 3) != 0;
         end
         if ($urandom_range(0, 99) < 45) begin
            send_tick();
         end else begin
            if ($urandom_range(0, 19) == 0 && big_waits < MAX_BIG_WAITS) begin
               secs = $urandom();
               big_waits++;
            end else begin
               secs = $urandom_range(0, 12);
            end
            send_add(8'($urandom()), secs);
         end
      end
      wait_drained();
   endtask

   initial begin : sequence_main
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_full_queue();
      test_extremes();
      test_backpressure();
      test_random_mix(130);
      if (awaited_rsps.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d results never arrived", $time, awaited_rsps.size());
      end
      $display("covered %0d request transfers: %0d adds accepted, %0d rejected full,",
               reqs_sent, seen_accepted, seen_rejected);
      $display("%0d expirations, seconds count reached %0d", seen_expired, model_seconds);
      if (mismatch_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/stq_pkg.sv
sv/stq_cell.sv
sv/sorted_timeout_queue.sv
dv/testbench.sv
